### hdl/vt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt_pkg
// Types and constants shared by the visit table core.
// ----------------------------------------------------------------------------
package vt_pkg;

  localparam int unsigned ENTRIES_DEF     = 1024;
  localparam int unsigned TRAIL_DEPTH_DEF = 1024;
  localparam int unsigned CHECKPOINTS_DEF = 64;
  localparam int unsigned MATCH_BITS_DEF  = 32;

  localparam logic [3:0] KIND_NONE  = 4'h0;
  localparam logic [3:0] KIND_OTHER = 4'hf;

  typedef enum logic [2:0] {
    ACT_PUT     = 3'd0,
    ACT_UNPUT   = 3'd1,
    ACT_QUERY   = 3'd2,
    ACT_COMPARE = 3'd3,
    ACT_PUSH    = 3'd4,
    ACT_BACK    = 3'd5,
    ACT_POP     = 3'd6,
    ACT_NOP     = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_TRAIL  = 2'd2,
    ST_STACK  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_OWN_RD,
    S_OWN_WR,
    S_BT_RD,
    S_BT_KEY,
    S_BT_REC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  key;
    logic [31:0] partner_id;
    logic [9:0]  owner_key;
    logic [1:0]  kind;
    logic [10:0] expected_count;
  } in_t;

  typedef struct packed {
    logic        inserted;
    logic        present;
    logic [31:0] matched_value;
    logic [3:0]  kind_flag;
    logic        count_equal;
    logic [10:0] visited_total;
    logic [1:0]  status;
  } out_t;

endpackage
`default_nettype wire

### hdl/visit_table_with_undo_trail_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// visit_table_with_undo_trail_core
// Visit table with undo trail and checkpoint stack for backtracking search.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the block sweeps the record and count
// memories, one entry a cycle, before it accepts the first item. An accepted
// item passes through a memory read state, an execute state and a state that
// loads the output register; query, compare, checkpoint and no-op actions, and
// puts that touch no owner count, take only these. A put of a new key with an
// owner, or an unput of a visited key with an owner, adds a read-modify-write
// of the owner's count in the single-port count memory; an unput of a visited
// key with no owner adds only the owner count read state. Backtrack steps
// through each undone trail entry (trail read, record read, owner count
// read-modify-write), with no owner count step for a stale entry and no write
// for one with no owner. The block returns to its idle state between items and
// takes a new item only once the last result is in the output register. Results
// are built in a work register and move to the output register once it is free,
// so a stalled result holds the block and delays the next acceptance.
module visit_table_with_undo_trail_core #(
  parameter int unsigned ENTRIES     = vt_pkg::ENTRIES_DEF,
  parameter int unsigned TRAIL_DEPTH = vt_pkg::TRAIL_DEPTH_DEF,
  parameter int unsigned CHECKPOINTS = vt_pkg::CHECKPOINTS_DEF,
  parameter int unsigned MATCH_BITS  = vt_pkg::MATCH_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire vt_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output vt_pkg::out_t      out_data_o
);

  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned TW = $clog2(TRAIL_DEPTH + 1);
  localparam int unsigned TA = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CHECKPOINTS + 1);
  localparam int unsigned CA = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = 4 + 10 + MATCH_BITS;

  // Record memory: kind, owner, partner.
  logic [RW-1:0] rec_mem [ENTRIES];
  logic [NW-1:0] cnt_mem [ENTRIES];
  logic [9:0]    trail_mem [TRAIL_DEPTH];
  logic [TW-1:0] ckpt_mem [CHECKPOINTS];

  vt_pkg::state_e state_q, state_d;
  vt_pkg::in_t    item_q, item_d;
  vt_pkg::out_t   out_q, out_d;
  vt_pkg::out_t   res_q, res_d;
  logic           out_valid_q, out_valid_d;
  logic [TW-1:0]  trail_len_q, trail_len_d;
  logic [CW-1:0]  ckpt_dep_q, ckpt_dep_d;
  logic [NW-1:0]  visited_q, visited_d;
  logic [EW-1:0]  clr_q, clr_d;
  logic [TW-1:0]  mark_q, mark_d;
  logic [9:0]     cur_key_q, cur_key_d;
  logic [9:0]     own_q, own_d;
  logic           own_inc_q, own_inc_d;

  // Memory ports
  logic          rec_we;
  logic [EW-1:0] rec_wa, rec_ra;
  logic [RW-1:0] rec_wd, rec_rd_q;
  logic          cnt_we;
  logic [EW-1:0] cnt_a;
  logic [NW-1:0] cnt_wd, cnt_rd_q;
  logic          tr_we;
  logic [TA-1:0] tr_wa, tr_ra;
  logic [9:0]    tr_rd_q;
  logic          ck_we;
  logic [CA-1:0] ck_wa, ck_ra;
  logic [TW-1:0] ck_rd_q;

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_q <= rec_mem[rec_ra];
  end
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_a] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_a];
  end
  always_ff @(posedge clk_i) begin
    if (tr_we) trail_mem[tr_wa] <= item_q.key;
    tr_rd_q <= trail_mem[tr_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ck_we) ckpt_mem[ck_wa] <= trail_len_q;
    ck_rd_q <= ckpt_mem[ck_ra];
  end

  // Decoded record fields
  logic [3:0]            rd_kind;
  logic [9:0]            rd_own;
  logic [MATCH_BITS-1:0] rd_part;
  assign rd_kind = rec_rd_q[RW-1 -: 4];
  assign rd_own  = rec_rd_q[MATCH_BITS +: 10];
  assign rd_part = rec_rd_q[MATCH_BITS-1:0];

  logic key_ok, own_ok;
  assign key_ok = {22'd0, item_q.key} < 32'(ENTRIES);
  assign own_ok = (item_q.owner_key == 10'd0) || ({22'd0, item_q.owner_key} < 32'(ENTRIES));

  logic [MATCH_BITS-1:0] part_in;
  logic [31:0]           part_out;
  always_comb begin
    if (MATCH_BITS >= 32) part_in = MATCH_BITS'(item_q.partner_id);
    else part_in = item_q.partner_id[MATCH_BITS-1:0];
  end
  always_comb begin
    if (MATCH_BITS >= 32) part_out = rd_part[31:0];
    else part_out = 32'(rd_part);
  end

  assign in_ready_o  = (state_q == vt_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control
  always_comb begin
    logic [3:0] nk;
    logic       own_in_range;
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    trail_len_d = trail_len_q;
    ckpt_dep_d  = ckpt_dep_q;
    visited_d   = visited_q;
    clr_d       = clr_q;
    mark_d      = mark_q;
    cur_key_d   = cur_key_q;
    own_d       = own_q;
    own_inc_d   = own_inc_q;
    rec_we = 1'b0; rec_wa = item_q.key[EW-1:0]; rec_ra = item_q.key[EW-1:0];
    rec_wd = '0;
    cnt_we = 1'b0; cnt_a = own_q[EW-1:0]; cnt_wd = '0;
    tr_we  = 1'b0; tr_wa = trail_len_q[TA-1:0];
    tr_ra  = TA'(trail_len_q - TW'(1));
    ck_we  = 1'b0; ck_wa = ckpt_dep_q[CA-1:0];
    ck_ra  = CA'(ckpt_dep_q - CW'(1));
    nk = (item_q.kind == 2'd0) ? vt_pkg::KIND_OTHER : {2'b00, item_q.kind};
    own_in_range = (own_q != 10'd0) && ({22'd0, own_q} < 32'(ENTRIES));

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      vt_pkg::S_CLEAR: begin
        rec_we = 1'b1; rec_wa = clr_q; cnt_we = 1'b1; cnt_a = clr_q;
        clr_d = clr_q + EW'(1);
        if (32'(clr_q) == ENTRIES - 1) state_d = vt_pkg::S_IDLE;
      end
      vt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = vt_pkg::S_READ;
        end
      end
      vt_pkg::S_READ: begin
        // memories read this cycle: record, key count, top checkpoint
        cnt_a   = item_q.key[EW-1:0];
        state_d = vt_pkg::S_EXEC;
      end
      vt_pkg::S_EXEC: begin
        res_d = '0;
        res_d.status = vt_pkg::ST_OK;
        state_d = vt_pkg::S_OUT;
        case (item_q.action)
          vt_pkg::ACT_PUT: begin
            if (!key_ok || !own_ok) res_d.status = vt_pkg::ST_RANGE;
            else if (rd_kind == vt_pkg::KIND_NONE) begin
              if (32'(trail_len_q) >= TRAIL_DEPTH) res_d.status = vt_pkg::ST_TRAIL;
              else begin
                visited_d = visited_q + NW'(1);
                rec_we = 1'b1;
                rec_wd = {nk, (item_q.owner_key != 10'd0) ? item_q.owner_key : 10'd0,
                          part_in};
                cur_key_d = item_q.key;
                tr_we = 1'b1;
                trail_len_d = trail_len_q + TW'(1);
                res_d.inserted = 1'b1;
                res_d.present = 1'b1;
                res_d.matched_value = (MATCH_BITS >= 32) ? item_q.partner_id
                                      : 32'(part_in);
                res_d.kind_flag = nk;
                own_d = item_q.owner_key; own_inc_d = 1'b1;
                if (item_q.owner_key != 10'd0) state_d = vt_pkg::S_OWN_RD;
              end
            end else begin
              rec_we = 1'b1;
              rec_wd = {nk, rd_own, rd_part};
              res_d.present = 1'b1;
              res_d.matched_value = part_out;
              res_d.kind_flag = nk;
            end
          end
          vt_pkg::ACT_UNPUT: begin
            if (!key_ok) res_d.status = vt_pkg::ST_RANGE;
            else if (rd_kind != vt_pkg::KIND_NONE) begin
              if (visited_q != '0) visited_d = visited_q - NW'(1);
              rec_we = 1'b1; rec_wd = '0;
              own_d = rd_own; own_inc_d = 1'b0;
              state_d = vt_pkg::S_OWN_RD;
            end
          end
          vt_pkg::ACT_QUERY: begin
            if (!key_ok) res_d.status = vt_pkg::ST_RANGE;
            else begin
              res_d.present = (rd_kind != vt_pkg::KIND_NONE);
              res_d.matched_value = part_out;
              res_d.kind_flag = rd_kind;
            end
          end
          vt_pkg::ACT_COMPARE: begin
            if (!key_ok) begin
              res_d.status = vt_pkg::ST_RANGE;
              res_d.count_equal = (item_q.expected_count == 11'd0);
            end else
              res_d.count_equal = (32'(cnt_rd_q) == 32'(item_q.expected_count));
          end
          vt_pkg::ACT_PUSH: begin
            if (32'(ckpt_dep_q) >= CHECKPOINTS) res_d.status = vt_pkg::ST_STACK;
            else begin
              ck_we = 1'b1;
              ckpt_dep_d = ckpt_dep_q + CW'(1);
            end
          end
          vt_pkg::ACT_BACK: begin
            if (ckpt_dep_q == '0) res_d.status = vt_pkg::ST_STACK;
            else begin
              mark_d = ck_rd_q;
              state_d = vt_pkg::S_BT_RD;
            end
          end
          vt_pkg::ACT_POP: begin
            if (ckpt_dep_q == '0) res_d.status = vt_pkg::ST_STACK;
            else ckpt_dep_d = ckpt_dep_q - CW'(1);
          end
          default: ;
        endcase
      end
      vt_pkg::S_OWN_RD: begin
        if (own_in_range) state_d = vt_pkg::S_OWN_WR;
        else state_d = (item_q.action == vt_pkg::ACT_BACK) ? vt_pkg::S_BT_RD
                       : vt_pkg::S_OUT;
      end
      vt_pkg::S_OWN_WR: begin
        cnt_we = 1'b1;
        if (own_inc_q)
          cnt_wd = (32'(cnt_rd_q) < ENTRIES) ? cnt_rd_q + NW'(1) : cnt_rd_q;
        else
          cnt_wd = (cnt_rd_q != '0) ? cnt_rd_q - NW'(1) : cnt_rd_q;
        state_d = (item_q.action == vt_pkg::ACT_BACK) ? vt_pkg::S_BT_RD
                  : vt_pkg::S_OUT;
      end
      vt_pkg::S_BT_RD: begin
        // pop one trail entry, or finish
        if (trail_len_q > mark_q) begin
          trail_len_d = trail_len_q - TW'(1);
          state_d = vt_pkg::S_BT_KEY;
        end else begin
          ckpt_dep_d = ckpt_dep_q - CW'(1);
          state_d = vt_pkg::S_OUT;
        end
      end
      vt_pkg::S_BT_KEY: begin
        rec_ra = tr_rd_q[EW-1:0];
        cur_key_d = tr_rd_q;
        state_d = vt_pkg::S_BT_REC;
      end
      vt_pkg::S_BT_REC: begin
        rec_wa = cur_key_q[EW-1:0];
        if ({22'd0, cur_key_q} < 32'(ENTRIES) && rd_kind != vt_pkg::KIND_NONE) begin
          if (visited_q != '0) visited_d = visited_q - NW'(1);
          rec_we = 1'b1; rec_wd = '0;
          own_d = rd_own; own_inc_d = 1'b0;
          state_d = vt_pkg::S_OWN_RD;
        end else state_d = vt_pkg::S_BT_RD;
      end
      vt_pkg::S_OUT: begin
        // move the finished result into the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = res_q;
          out_d.visited_total = 11'(visited_q);
          state_d = vt_pkg::S_IDLE;
        end
      end
      default: state_d = vt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vt_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
      trail_len_q <= '0;
      ckpt_dep_q  <= '0;
      visited_q   <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      trail_len_q <= trail_len_d;
      ckpt_dep_q  <= ckpt_dep_d;
      visited_q   <= visited_d;
      clr_q       <= clr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    out_q     <= out_d;
    res_q     <= res_d;
    mark_q    <= mark_d;
    cur_key_q <= cur_key_d;
    own_q     <= own_d;
    own_inc_q <= own_inc_d;
  end

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the visit table core: directed and random
// put/unput/query/compare/checkpoint traffic with random stalls on both
// channels, checked field by field against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NENT = 1024;
  localparam int NTRAIL = 1024;
  localparam int NCKPT = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vt_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  vt_pkg::out_t out_data_o;

  visit_table_with_undo_trail_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the visit table
  logic [3:0]  kind_mem  [NENT];
  logic [9:0]  owner_mem [NENT];
  logic [31:0] match_mem [NENT];
  int          kids_mem  [NENT];
  int          trail_mem [NTRAIL];
  int          trail_len;
  int          ckpt_mem  [NCKPT];
  int          ckpt_top;
  int          visits;

  vt_pkg::in_t  pending_q[$];
  vt_pkg::out_t expected_q[$];
  int   errors = 0;
  bit   stim_done = 1'b0;
  bit   hold_input = 1'b0;

  function automatic void drop_visit(int k);
    int own;
    if (kind_mem[k] == vt_pkg::KIND_NONE) return;
    if (visits > 0) visits--;
    own = int'(owner_mem[k]);
    if (own != 0 && kids_mem[own] > 0) kids_mem[own]--;
    kind_mem[k] = vt_pkg::KIND_NONE;
    owner_mem[k] = '0;
    match_mem[k] = '0;
  endfunction

  // compute the result of one transaction and update the shadow table
  function automatic vt_pkg::out_t visit_result(vt_pkg::in_t it);
    vt_pkg::out_t r;
    bit show;
    int k;
    show = 1'b0;
    r = '0;
    k = int'(it.key);
    r.status = vt_pkg::ST_OK;
    case (vt_pkg::action_e'(it.action))
      vt_pkg::ACT_PUT: begin
        if (k >= NENT || (it.owner_key != 0 && int'(it.owner_key) >= NENT)) begin
          r.status = vt_pkg::ST_RANGE;
        end else if (kind_mem[k] == vt_pkg::KIND_NONE && trail_len >= NTRAIL) begin
          r.status = vt_pkg::ST_TRAIL;
        end else begin
          if (kind_mem[k] == vt_pkg::KIND_NONE) begin
            visits++;
            match_mem[k] = it.partner_id;
            if (it.owner_key != 0) begin
              owner_mem[k] = it.owner_key;
              if (kids_mem[it.owner_key] < NENT) kids_mem[it.owner_key]++;
            end
            trail_mem[trail_len] = k;
            trail_len++;
            r.inserted = 1'b1;
          end
          kind_mem[k] = (it.kind == 0) ? vt_pkg::KIND_OTHER : {2'b00, it.kind};
          show = 1'b1;
        end
      end
      vt_pkg::ACT_UNPUT: begin
        drop_visit(k);
        show = 1'b1;
      end
      vt_pkg::ACT_QUERY: show = 1'b1;
      vt_pkg::ACT_COMPARE: r.count_equal = (kids_mem[k] == int'(it.expected_count));
      vt_pkg::ACT_PUSH: begin
        if (ckpt_top >= NCKPT) r.status = vt_pkg::ST_STACK;
        else begin
          ckpt_mem[ckpt_top] = trail_len;
          ckpt_top++;
        end
      end
      vt_pkg::ACT_BACK: begin
        if (ckpt_top == 0) r.status = vt_pkg::ST_STACK;
        else begin
          while (trail_len > ckpt_mem[ckpt_top-1]) begin
            trail_len--;
            drop_visit(trail_mem[trail_len]);
          end
          ckpt_top--;
        end
      end
      vt_pkg::ACT_POP: begin
        if (ckpt_top == 0) r.status = vt_pkg::ST_STACK;
        else ckpt_top--;
      end
      default: ;
    endcase
    if (show) begin
      r.present = (kind_mem[k] != vt_pkg::KIND_NONE);
      r.matched_value = match_mem[k];
      r.kind_flag = kind_mem[k];
    end
    r.visited_total = visits[10:0];
    return r;
  endfunction

  function automatic vt_pkg::in_t make_item(vt_pkg::action_e a, int k, logic [31:0] p,
                                            int own, int kd, int cnt);
    vt_pkg::in_t it;
    it.action = a;
    it.key = 10'(k);
    it.partner_id = p;
    it.owner_key = 10'(own);
    it.kind = 2'(kd);
    it.expected_count = 11'(cnt);
    return it;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: input channel
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      void'(pending_q.pop_front());
      expected_q.push_back(visit_result(in_data_i));
      send_gap = gap_len();
    end
    if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0 || hold_input || pending_q.size() == 0 || !rst_ni) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q[0];
      end
    end
  end

  // monitor: output channel with random stalls
  int stall = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else if (out_data_o !== expected_q[0]) begin
        errors++;
        $display("%0t: expected %p actual %p", $time, expected_q[0], out_data_o);
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
      stall = gap_len();
    end
    if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic vt_pkg::in_t random_item();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NENT - 1) : $urandom_range(0, 40);
    if (r < 40)
      return make_item(vt_pkg::ACT_PUT, k, $urandom(),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40),
                       $urandom_range(0, 3), $urandom_range(0, 2047));
    if (r < 50) return make_item(vt_pkg::ACT_UNPUT, k, $urandom(), $urandom_range(0, 1023),
                                 $urandom_range(0, 3), $urandom_range(0, 2047));
    if (r < 60) return make_item(vt_pkg::ACT_QUERY, k, $urandom(), $urandom_range(0, 1023),
                                 $urandom_range(0, 3), $urandom_range(0, 2047));
    if (r < 72) return make_item(vt_pkg::ACT_COMPARE, $urandom_range(0, 40), $urandom(),
                                 0, 0,
                                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                             : $urandom_range(0, 6));
    if (r < 82) return make_item(vt_pkg::ACT_PUSH, k, $urandom(), 0, 0, 0);
    if (r < 92) return make_item(vt_pkg::ACT_BACK, k, $urandom(), 0, 0, 0);
    if (r < 98) return make_item(vt_pkg::ACT_POP, k, $urandom(), 0, 0, 0);
    return make_item(vt_pkg::ACT_NOP, k, $urandom(), $urandom_range(0, 1023),
                     $urandom_range(0, 3), $urandom_range(0, 2047));
  endfunction

  initial begin
    int n;
    for (int i = 0; i < NENT; i++) begin
      kind_mem[i] = vt_pkg::KIND_NONE;
      owner_mem[i] = '0;
      match_mem[i] = '0;
      kids_mem[i] = 0;
    end
    trail_len = 0;
    ckpt_top = 0;
    visits = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every action, error paths
    pending_q.push_back(make_item(vt_pkg::ACT_BACK, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_POP, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 1023, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_PUSH, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_PUT, 1023, 32'hffff_ffff, 1023, 3, 2047));
    pending_q.push_back(make_item(vt_pkg::ACT_PUT, 1023, 32'h0, 1023, 2, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_PUT, 5, 32'h1234_5678, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_PUT, 0, 32'haaaa_5555, 0, 1, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_PUT, 7, 32'h5555_aaaa, 7, 1, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 1023, 0, 0, 0, 1));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 7, 0, 0, 0, 1));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_QUERY, 5, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_UNPUT, 7, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_UNPUT, 7, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 7, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_NOP, 1023, 32'hffff_ffff, 1023, 3, 2047));
    pending_q.push_back(make_item(vt_pkg::ACT_BACK, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_QUERY, 1023, 0, 0, 0, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, 1023, 0, 0, 0, 0));
    for (int i = 0; i < 66; i++)
      pending_q.push_back(make_item(vt_pkg::ACT_PUSH, i, 0, 0, 0, 0));
    for (int i = 0; i < 66; i++)
      pending_q.push_back(make_item(vt_pkg::ACT_POP, i, 0, 0, 0, 0));

    // random: short search episodes of push, puts, back; plus noise
    n = 0;
    while (n < 670) begin
      if ($urandom_range(0, 3) != 0) begin
        int len;
        len = $urandom_range(1, 12);
        pending_q.push_back(make_item(vt_pkg::ACT_PUSH, 0, $urandom(), 0, 0, 0));
        for (int j = 0; j < len; j++) begin
          pending_q.push_back(make_item(vt_pkg::ACT_PUT, $urandom_range(1, 60), $urandom(),
                                        $urandom_range(0, 60), $urandom_range(0, 3), 0));
          if ($urandom_range(0, 3) == 0)
            pending_q.push_back(make_item(vt_pkg::ACT_COMPARE, $urandom_range(0, 60), 0, 0,
                                          0, $urandom_range(0, 4)));
        end
        pending_q.push_back(make_item(($urandom_range(0, 4) == 0) ? vt_pkg::ACT_POP
                                                                  : vt_pkg::ACT_BACK,
                                      0, 0, 0, 0, 0));
        n += len + 2;
      end else begin
        pending_q.push_back(random_item());
        n++;
      end
      if (n > 300 && n < 315) begin
        // let everything drain before continuing
        wait (pending_q.size() == 0);
        hold_input = 1'b1;
        wait (expected_q.size() == 0 && !in_valid_i);
        hold_input = 1'b0;
      end
    end
    // fill the trail to capacity to hit the trail-full case
    for (int i = 0; i < 1030; i++)
      pending_q.push_back(make_item(vt_pkg::ACT_PUT, i, i, 0, 1, 0));
    pending_q.push_back(make_item(vt_pkg::ACT_QUERY, 1023, 0, 0, 0, 0));
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("visit_table_with_undo_trail_core: match");
    end else begin
      $display("visit_table_with_undo_trail_core: mismatch");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("visit_table_with_undo_trail_core: mismatch");
    $finish;
  end
endmodule
